FILE: sv/ptsd_pkg.sv
`default_nettype none
package ptsd_pkg;

  // Fraction bits of the projection parameter t.
  localparam int T_FRAC_BITS = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_X   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y   = 2'd3;

endpackage
`default_nettype wire

FILE: sv/point_to_segment_distance_top.sv
`default_nettype none
// Point to line segment distance.
// The segment endpoints are four configuration registers written through
// wr_en, wr_index and wr_data (start_x, start_y, end_x, end_y at indexes 0 to
// 3); write them only while no point is in flight. A query point word is
// accepted on each cycle with start high; busy is always low, so one point
// can enter every clock cycle.
// Each point gives exactly one result word: distance (unsigned, with
// DIST_FRAC_BITS fraction bits) and degenerate, shown for one cycle with
// done high. Results come out in input order.
// The pipeline has four stages that form the dot products and classify the
// projection, 16 stages that divide out the projection parameter one quotient
// bit each, four stages that form the squared error, and a square root that
// yields one root bit per stage.
// Throughput is one word per cycle.
// Reset clears the endpoint registers to zero and empties the pipeline. The
// receiver cannot stall, so nothing is ever held back.
module point_to_segment_distance_top #(
  parameter int COORD_BITS     = 16,
  parameter int DIST_FRAC_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [COORD_BITS-1:0]          point_x,
  input  wire logic signed [COORD_BITS-1:0]          point_y,
  output logic                                       done,
  output logic [COORD_BITS+DIST_FRAC_BITS:0]         distance,
  output logic                                       degenerate,
  input  wire logic                                  wr_en,
  input  wire logic [ptsd_pkg::CFG_INDEX_BITS-1:0]   wr_index,
  input  wire logic [COORD_BITS-1:0]                 wr_data
);

  localparam int C   = COORD_BITS;
  localparam int T   = ptsd_pkg::T_FRAC_BITS;
  localparam int D   = C + 1;            // coordinate differences
  localparam int PW  = 2 * D;            // products and length
  localparam int NW  = 2 * D + 1;        // dot product, signed
  localparam int QW  = 2 * D + 1;        // divider remainder
  localparam int TW  = T + 1;            // t, 0 to 1.0
  localparam int EW  = D + T + 2;        // error in Q.T
  localparam int AW  = EW - (T - DIST_FRAC_BITS);
  localparam int SW  = 2 * AW + 1;
  localparam int SR  = (SW + 1) / 2;
  localparam int DW  = C + 1 + DIST_FRAC_BITS;

  assign busy = 1'b0;

  // Endpoint registers.
  logic signed [C-1:0] start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ptsd_pkg::REG_START_X: start_x <= wr_data;
        ptsd_pkg::REG_START_Y: start_y <= wr_data;
        ptsd_pkg::REG_END_X:   end_x   <= wr_data;
        ptsd_pkg::REG_END_Y:   end_y   <= wr_data;
        default: ;
      endcase
    end
  end

  // Stage 1: differences.
  logic                s1_v;
  logic signed [D-1:0] s1_rx, s1_ry, s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_rx <= D'(point_x) - D'(start_x);
    s1_ry <= D'(point_y) - D'(start_y);
    s1_dx <= D'(end_x) - D'(start_x);
    s1_dy <= D'(end_y) - D'(start_y);
  end

  // Stage 2: the four products.
  logic                 s2_v;
  logic signed [D-1:0]  s2_rx, s2_ry, s2_dx, s2_dy;
  logic signed [PW-1:0] s2_rxdx, s2_rydy, s2_dxdx, s2_dydy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_rx   <= s1_rx;
    s2_ry   <= s1_ry;
    s2_dx   <= s1_dx;
    s2_dy   <= s1_dy;
    s2_rxdx <= s1_rx * s1_dx;
    s2_rydy <= s1_ry * s1_dy;
    s2_dxdx <= s1_dx * s1_dx;
    s2_dydy <= s1_dy * s1_dy;
  end

  // Stage 3: squared length and dot product.
  logic                 s3_v;
  logic signed [D-1:0]  s3_rx, s3_ry, s3_dx, s3_dy;
  logic [PW-1:0]        s3_len;
  logic signed [NW-1:0] s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_rx  <= s2_rx;
    s3_ry  <= s2_ry;
    s3_dx  <= s2_dx;
    s3_dy  <= s2_dy;
    s3_len <= PW'($unsigned(s2_dxdx)) + PW'($unsigned(s2_dydy));
    s3_num <= NW'(s2_rxdx) + NW'(s2_rydy);
  end

  // Divider pipeline: index 0 is loaded from stage 3, one quotient bit per stage.
  logic                dv_v    [0:T];
  logic                dv_deg  [0:T];
  logic                dv_zero [0:T];
  logic                dv_one  [0:T];
  logic [QW-1:0]       dv_r    [0:T];
  logic [PW-1:0]       dv_l    [0:T];
  logic [T-1:0]        dv_q    [0:T];
  logic signed [D-1:0] dv_rx   [0:T];
  logic signed [D-1:0] dv_ry   [0:T];
  logic signed [D-1:0] dv_dx   [0:T];
  logic signed [D-1:0] dv_dy   [0:T];

  // Classify the projection and load the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= s3_v;
    end
    dv_deg[0]  <= (s3_len == '0);
    dv_zero[0] <= (s3_len == '0) || (s3_num <= 0);
    dv_one[0]  <= (s3_num > 0) && ($unsigned(s3_num) >= QW'(s3_len));
    dv_r[0]    <= $unsigned(s3_num);
    dv_l[0]    <= s3_len;
    dv_q[0]    <= '0;
    dv_rx[0]   <= s3_rx;
    dv_ry[0]   <= s3_ry;
    dv_dx[0]   <= s3_dx;
    dv_dy[0]   <= s3_dy;
  end

  for (genvar k = 0; k < T; k++) begin : g_div
    logic [QW-1:0] r_sh;
    logic          ge;

    // Shift the remainder and subtract the length where it fits.
    always_comb begin
      r_sh = {dv_r[k][QW-2:0], 1'b0};
      ge   = (r_sh >= QW'(dv_l[k]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
      dv_deg[k+1]  <= dv_deg[k];
      dv_zero[k+1] <= dv_zero[k];
      dv_one[k+1]  <= dv_one[k];
      dv_l[k+1]    <= dv_l[k];
      dv_rx[k+1]   <= dv_rx[k];
      dv_ry[k+1]   <= dv_ry[k];
      dv_dx[k+1]   <= dv_dx[k];
      dv_dy[k+1]   <= dv_dy[k];
      if (ge) begin
        dv_r[k+1] <= r_sh - QW'(dv_l[k]);
        dv_q[k+1] <= {dv_q[k][T-2:0], 1'b1};
      end else begin
        dv_r[k+1] <= r_sh;
        dv_q[k+1] <= {dv_q[k][T-2:0], 1'b0};
      end
    end
  end

  // Final t after clamping.
  logic [TW-1:0] t_sel;

  always_comb begin
    if (dv_zero[T]) begin
      t_sel = '0;
    end else if (dv_one[T]) begin
      t_sel = TW'(1) << T;
    end else begin
      t_sel = {1'b0, dv_q[T]};
    end
  end

  // Error stage 1: t times the direction.
  logic                    e1_v, e1_deg;
  logic signed [D-1:0]     e1_rx, e1_ry;
  logic signed [D+TW:0]    e1_tx, e1_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else begin
      e1_v <= dv_v[T];
    end
    e1_deg <= dv_deg[T];
    e1_rx  <= dv_rx[T];
    e1_ry  <= dv_ry[T];
    e1_tx  <= $signed({1'b0, t_sel}) * dv_dx[T];
    e1_ty  <= $signed({1'b0, t_sel}) * dv_dy[T];
  end

  // Error stage 2: error vector, magnitude and truncation.
  logic signed [EW-1:0] ex, ey;
  logic [EW-1:0]        ex_mag, ey_mag;

  always_comb begin
    ex     = (EW'(e1_rx) <<< T) - EW'(e1_tx);
    ey     = (EW'(e1_ry) <<< T) - EW'(e1_ty);
    ex_mag = ex[EW-1] ? EW'(-ex) : EW'(ex);
    ey_mag = ey[EW-1] ? EW'(-ey) : EW'(ey);
  end

  logic          e2_v, e2_deg;
  logic [AW-1:0] e2_ax, e2_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_v <= 1'b0;
    end else begin
      e2_v <= e1_v;
    end
    e2_deg <= e1_deg;
    e2_ax  <= AW'(ex_mag >> (T - DIST_FRAC_BITS));
    e2_ay  <= AW'(ey_mag >> (T - DIST_FRAC_BITS));
  end

  // Error stage 3: squares.
  logic            e3_v, e3_deg;
  logic [2*AW-1:0] e3_sx, e3_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_v <= 1'b0;
    end else begin
      e3_v <= e2_v;
    end
    e3_deg <= e2_deg;
    e3_sx  <= e2_ax * e2_ax;
    e3_sy  <= e2_ay * e2_ay;
  end

  // Error stage 4: squared distance.
  logic          e4_v, e4_deg;
  logic [SW-1:0] e4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      e4_v <= 1'b0;
    end else begin
      e4_v <= e3_v;
    end
    e4_deg <= e3_deg;
    e4_sum <= SW'(e3_sx) + SW'(e3_sy);
  end

  // Square root.
  logic [SR-1:0] root;

  ptsd_sqrt #(
    .IN_W (SW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e4_v),
    .radicand  (e4_sum),
    .in_tag    (e4_deg),
    .out_valid (done),
    .root      (root),
    .out_tag   (degenerate)
  );

  assign distance = root[DW-1:0];

endmodule
`default_nettype wire

FILE: sv/ptsd_sqrt.sv
`default_nettype none
// Pipelined restoring square root: one root bit per stage.
module ptsd_sqrt #(
  parameter int IN_W = 55
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic [IN_W-1:0]         radicand,
  input  wire logic                    in_tag,
  output logic                         out_valid,
  output logic [(IN_W+1)/2-1:0]        root,
  output logic                         out_tag
);

  localparam int SR = (IN_W + 1) / 2;
  localparam int RW = 2 * SR;
  localparam int MW = SR + 2;

  logic          vld [1:SR];
  logic          tag [1:SR];
  logic [RW-1:0] rad [1:SR];
  logic [MW-1:0] rem [1:SR];
  logic [SR-1:0] res [1:SR];

  for (genvar k = 0; k < SR; k++) begin : g_stage
    logic          v_in;
    logic          t_in;
    logic [RW-1:0] rad_in;
    logic [MW-1:0] rem_in;
    logic [SR-1:0] res_in;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          fits;

    if (k == 0) begin : g_first
      // The first stage takes the input word with an empty remainder.
      always_comb begin
        v_in   = in_valid;
        t_in   = in_tag;
        rad_in = RW'(radicand);
        rem_in = '0;
        res_in = '0;
      end
    end else begin : g_next
      // Later stages take the word of the stage before.
      always_comb begin
        v_in   = vld[k];
        t_in   = tag[k];
        rad_in = rad[k];
        rem_in = rem[k];
        res_in = res[k];
      end
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {rem_in[SR-1:0], rad_in[RW-1-2*k -: 2]};
      trial  = {res_in, 2'b01};
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_in;
      end
      tag[k+1] <= t_in;
      rad[k+1] <= rad_in;
      if (fits) begin
        rem[k+1] <= rem_sh - trial;
        res[k+1] <= {res_in[SR-2:0], 1'b1};
      end else begin
        rem[k+1] <= rem_sh;
        res[k+1] <= {res_in[SR-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[SR];
  assign root      = res[SR];
  assign out_tag   = tag[SR];

endmodule
`default_nettype wire

FILE: test/tb_point_to_segment_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_point_to_segment_distance_top;

  localparam int CB = 16;
  localparam int FB = 8;
  localparam int DW = CB + FB + 1;
  localparam int LATENCY = 52;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic          degenerate;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] point_x = '0;
  logic signed [CB-1:0] point_y = '0;
  logic done;
  logic [DW-1:0] distance;
  logic degenerate;
  logic wr_en = 1'b0;
  logic [ptsd_pkg::CFG_INDEX_BITS-1:0] wr_index = ptsd_pkg::REG_START_X;
  logic [CB-1:0] wr_data = '0;

  // Local copy of the segment endpoints.
  logic signed [CB-1:0] seg_sx, seg_sy, seg_ex, seg_ey;

  dist_word_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;

  point_to_segment_distance_top #(.COORD_BITS(CB), .DIST_FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .done(done),
    .distance(distance), .degenerate(degenerate),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  // Integer square root, truncated.
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Error magnitude along one axis, truncated to the distance fraction.
  function automatic logic [63:0] axis_error(input longint rel, input longint t,
                                             input longint d);
    longint e;
    logic [63:0] u;
    e = rel * (64'sd1 <<< ptsd_pkg::T_FRAC_BITS) - t * d;
    u = (e < 0) ? -e : e;
    return u >> (ptsd_pkg::T_FRAC_BITS - FB);
  endfunction

  // Predicts the distance of one point to the current segment.
  function automatic dist_word_t segment_distance(input logic signed [CB-1:0] px,
                                                  input logic signed [CB-1:0] py);
    longint dx, dy, rx, ry, len, num, t;
    logic [63:0] r, q, ax, ay;
    dist_word_t w;
    dx = longint'(seg_ex) - longint'(seg_sx);
    dy = longint'(seg_ey) - longint'(seg_sy);
    rx = longint'(px) - longint'(seg_sx);
    ry = longint'(py) - longint'(seg_sy);
    len = dx * dx + dy * dy;
    num = rx * dx + ry * dy;
    t = 0;
    if (len != 0) begin
      if (num <= 0) begin
        t = 0;
      end else if (num >= len) begin
        t = 64'sd1 <<< ptsd_pkg::T_FRAC_BITS;
      end else begin
        r = num;
        q = '0;
        for (int i = 0; i < ptsd_pkg::T_FRAC_BITS; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= len) begin
            r = r - len;
            q[0] = 1'b1;
          end
        end
        t = q;
      end
    end
    ax = axis_error(rx, t, dx);
    ay = axis_error(ry, t, dy);
    w.distance = DW'(root_floor(ax * ax + ay * ay));
    w.degenerate = (len == 0);
    return w;
  endfunction

  // Checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: distance %0d", distance);
      end else begin
        dist_word_t w;
        w = expected_q.pop_front();
        if (w.distance !== distance || w.degenerate !== degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected distance %0d degenerate %0b, got %0d %0b",
                     w.distance, w.degenerate, distance, degenerate);
        end
      end
    end
  end

  // Ends the run when no word is accepted or returned for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_point_to_segment_distance_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_point(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
                            input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(segment_distance(px, py));
    @(negedge clk);
  endtask

  task automatic drain;
    int waited;
    start <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 10 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ptsd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [CB-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      ptsd_pkg::REG_START_X: seg_sx = val;
      ptsd_pkg::REG_START_Y: seg_sy = val;
      ptsd_pkg::REG_END_X:   seg_ex = val;
      default:               seg_ey = val;
    endcase
  endtask

  task automatic set_segment(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                             input logic [CB-1:0] ex, input logic [CB-1:0] ey);
    drain();
    write_reg(ptsd_pkg::REG_START_X, sx);
    write_reg(ptsd_pkg::REG_START_Y, sy);
    write_reg(ptsd_pkg::REG_END_X, ex);
    write_reg(ptsd_pkg::REG_END_Y, ey);
  endtask

  // Zero-length segment at reset values, then the coordinate extremes.
  task automatic test_degenerate;
    send_point(16'sh0000, 16'sh0000, 0);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh8000, 16'sh8000, 0);
    set_segment(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh8000, 16'sh7fff, 0);
  endtask

  // Points before, beyond and inside the segment, on extreme segments and a short one.
  task automatic test_clamping;
    set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_point(16'sh8000, 16'sh7fff, 0);
    send_point(16'sh7fff, 16'sh8000, 0);
    send_point(16'sh8000, 16'sh8000, 0);
    send_point(16'sh7fff, 16'sh7fff, 0);
    send_point(16'sh0000, 16'sh0001, 0);
    set_segment(16'd0, 16'd0, 16'd100, 16'd0);
    send_point(-16'sd5, 16'sd3, 0);
    send_point(16'sd105, -16'sd3, 0);
    send_point(16'sd33, 16'sd7, 0);
    send_point(16'sd50, 16'sd0, 0);
    set_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_point(16'sh0000, 16'sh0000, 0);
    send_point(16'sh7fff, 16'sh7fff, 0);
  endtask

  // Random points on random segments, mostly short ones near the points.
  task automatic test_random;
    logic signed [CB-1:0] sx, sy, ex, ey, px, py;
    for (int phase = 0; phase < 19; phase++) begin
      sx = CB'($urandom);
      sy = CB'($urandom);
      if (phase % 3 == 0) begin
        ex = CB'($urandom);
        ey = CB'($urandom);
      end else begin
        sx = sx >>> 2;
        sy = sy >>> 2;
        ex = CB'(sx + $signed(CB'($urandom_range(0, 400))) - 200);
        ey = CB'(sy + $signed(CB'($urandom_range(0, 400))) - 200);
        if (phase % 7 == 1) begin
          ex = sx;
          ey = sy;
        end
      end
      set_segment(sx, sy, ex, ey);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          px = CB'($urandom);
          py = CB'($urandom);
        end else begin
          px = CB'(sx + $signed(CB'($urandom_range(0, 1000))) - 500);
          py = CB'(sy + $signed(CB'($urandom_range(0, 1000))) - 500);
        end
        send_point(px, py, (phase % 4) != 0);
      end
    end
  endtask

  initial begin
    seg_sx = '0;
    seg_sy = '0;
    seg_ex = '0;
    seg_ey = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_degenerate();
    test_clamping();
    test_random();
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_point_to_segment_distance_top: PASS");
    end else begin
      $display("tb_point_to_segment_distance_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/ptsd_pkg.sv
sv/ptsd_sqrt.sv
sv/point_to_segment_distance_top.sv
test/tb_point_to_segment_distance_top.sv
